/* hdl/reb_pkg.sv */
// Shared types, constants and helpers for the rotary encoder and button event block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package reb_pkg;

  // Event codes carried on the result channel.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CW     = 3'd1,
    EV_CCW    = 3'd2,
    EV_CLICK  = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LONG   = 3'd5
  } event_code_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_PRESS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET   = 16'd600;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_PRESS_RESET = 16'd300;

  localparam int NOW_W = 32;

  // Parameter defaults.
  localparam int TIME_BITS_DEFAULT        = 32;
  localparam int STEPS_PER_DETENT_DEFAULT = 2;

  // Transition codes: previous A, previous B, current A, current B.
  localparam logic [3:0] TR_FWD_0 = 4'b1101;
  localparam logic [3:0] TR_FWD_1 = 4'b0100;
  localparam logic [3:0] TR_FWD_2 = 4'b0010;
  localparam logic [3:0] TR_FWD_3 = 4'b1011;
  localparam logic [3:0] TR_REV_0 = 4'b1110;
  localparam logic [3:0] TR_REV_1 = 4'b0111;
  localparam logic [3:0] TR_REV_2 = 4'b0001;
  localparam logic [3:0] TR_REV_3 = 4'b1000;

  // Pin and switch levels of one sample, passed from the input register to the core.
  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic switch_level;
  } sample_ctl_t;

  function automatic logic is_forward(input logic [3:0] trans);
    return (trans == TR_FWD_0) || (trans == TR_FWD_1) ||
           (trans == TR_FWD_2) || (trans == TR_FWD_3);
  endfunction

  function automatic logic is_reverse(input logic [3:0] trans);
    return (trans == TR_REV_0) || (trans == TR_REV_1) ||
           (trans == TR_REV_2) || (trans == TR_REV_3);
  endfunction

endpackage

`default_nettype wire

/* hdl/reb_event_core.sv */
// Event decision logic and the encoder/button state it keeps.
// Depends on reb_pkg for event codes, transition codes and the sample struct.
`timescale 1ns / 1ps
`default_nettype none

module reb_event_core #(
  parameter int TIME_BITS        = reb_pkg::TIME_BITS_DEFAULT,
  parameter int STEPS_PER_DETENT = reb_pkg::STEPS_PER_DETENT_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire reb_pkg::sample_ctl_t              sample,
  input  wire logic [TIME_BITS-1:0]              now,
  input  wire logic [reb_pkg::CFG_DATA_W-1:0]    long_press_ms,
  input  wire logic [reb_pkg::CFG_DATA_W-1:0]    double_press_ms,
  output reb_pkg::event_code_t                   event_next
);

  // The count needs room for +/-STEPS_PER_DETENT before it is cleared.
  localparam int CNT_W = $clog2(STEPS_PER_DETENT + 1) + 1;
  localparam logic signed [CNT_W-1:0] STEP_MAX = CNT_W'(STEPS_PER_DETENT);
  localparam logic signed [CNT_W-1:0] STEP_MIN = -STEP_MAX;

  logic [1:0]                  last_pins, last_pins_next;
  logic signed [CNT_W-1:0]     step_count, step_count_next;
  logic                        held, held_next;
  logic [TIME_BITS-1:0]        press_start, press_start_next;
  logic                        click_pending, click_pending_next;
  logic [TIME_BITS-1:0]        click_stamp, click_stamp_next;

  logic [1:0]              pins;
  logic [3:0]              trans;
  logic signed [CNT_W-1:0] cnt_step;
  logic                    pressed;
  logic [TIME_BITS-1:0]    hold_time;
  logic [TIME_BITS-1:0]    click_age;
  logic [TIME_BITS-1:0]    long_ext;
  logic [TIME_BITS-1:0]    double_ext;

  always_comb begin
    pins       = {sample.pin_a, sample.pin_b};
    trans      = {last_pins, pins};
    pressed    = ~sample.switch_level;
    hold_time  = now - press_start;
    click_age  = now - click_stamp;
    long_ext   = TIME_BITS'(long_press_ms);
    double_ext = TIME_BITS'(double_press_ms);

    cnt_step = step_count;
    if (reb_pkg::is_forward(trans)) begin
      cnt_step = step_count + CNT_W'(1);
    end else if (reb_pkg::is_reverse(trans)) begin
      cnt_step = step_count - CNT_W'(1);
    end

    last_pins_next     = pins;
    step_count_next    = cnt_step;
    held_next          = held;
    press_start_next   = press_start;
    click_pending_next = click_pending;
    click_stamp_next   = click_stamp;
    event_next         = reb_pkg::EV_NONE;

    // A completed detent wins over the button and leaves its state alone.
    if (cnt_step >= STEP_MAX) begin
      step_count_next = '0;
      event_next      = reb_pkg::EV_CW;
    end else if (cnt_step <= STEP_MIN) begin
      step_count_next = '0;
      event_next      = reb_pkg::EV_CCW;
    end else if (pressed && !held) begin
      held_next        = 1'b1;
      press_start_next = now;
      if (click_pending && (click_age > double_ext)) begin
        click_pending_next = 1'b0;
        event_next         = reb_pkg::EV_CLICK;
      end
    end else if (!pressed && held) begin
      held_next = 1'b0;
      priority if (hold_time > long_ext) begin
        event_next = reb_pkg::EV_LONG;
      end else if (click_pending && (click_age < double_ext)) begin
        click_pending_next = 1'b0;
        event_next         = reb_pkg::EV_DOUBLE;
      end else begin
        // This release starts a new window; it cannot expire in the same sample.
        click_pending_next = 1'b1;
        click_stamp_next   = now;
      end
    end else if (click_pending && (click_age > double_ext)) begin
      click_pending_next = 1'b0;
      event_next         = reb_pkg::EV_CLICK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins     <= '0;
      step_count    <= '0;
      held          <= 1'b0;
      press_start   <= '0;
      click_pending <= 1'b0;
      click_stamp   <= '0;
    end else if (advance) begin
      last_pins     <= last_pins_next;
      step_count    <= step_count_next;
      held          <= held_next;
      press_start   <= press_start_next;
      click_pending <= click_pending_next;
      click_stamp   <= click_stamp_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/rotary_encoder_button_events_top.sv */
// Top level of the rotary encoder and button event block: handshakes,
// configuration registers, input and result registers. Uses reb_pkg and reb_event_core.
//
// Usage: every request on the input channel (in_valid/in_ready) is one sample
// of pin_a, pin_b, switch_level and the millisecond timestamp now_ms. Each
// request yields exactly one result on the output channel (out_valid/out_ready)
// carrying event_code: none, clockwise, counter-clockwise, click, double click
// or long press.
// Each accepted request is held in the input register, then the decision logic
// loads the result register from it.
// Throughput is one request per cycle while the receiver takes results; the
// state update of one sample feeds the next sample directly, so consecutive
// samples need no gap.
// When the receiver stalls, the result register holds its value and the input
// register holds the next sample; in_ready drops only once both are full.
// Reset (rst, synchronous) empties both registers, clears the encoder and button
// state, and restores long_press_ms to 600 and double_press_ms to 300.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and
// are meant for an idle block.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_button_events_top #(
  parameter int TIME_BITS        = reb_pkg::TIME_BITS_DEFAULT,
  parameter int STEPS_PER_DETENT = reb_pkg::STEPS_PER_DETENT_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              pin_a,
  input  wire logic                              pin_b,
  input  wire logic                              switch_level,
  input  wire logic [reb_pkg::NOW_W-1:0]         now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             event_code,
  input  wire logic                              cfg_wr_en,
  input  wire logic [reb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [reb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int KEEP_W = (TIME_BITS < reb_pkg::NOW_W) ? TIME_BITS : reb_pkg::NOW_W;

  logic [reb_pkg::CFG_DATA_W-1:0] long_press_ms;
  logic [reb_pkg::CFG_DATA_W-1:0] double_press_ms;

  logic                 s1_valid;
  reb_pkg::sample_ctl_t s1_sample;
  logic [TIME_BITS-1:0] s1_now;

  logic                 advance;
  reb_pkg::event_code_t event_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms   <= reb_pkg::LONG_PRESS_RESET;
      double_press_ms <= reb_pkg::DOUBLE_PRESS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        reb_pkg::REG_LONG_PRESS:   long_press_ms   <= cfg_data;
        reb_pkg::REG_DOUBLE_PRESS: double_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample.pin_a        <= pin_a;
      s1_sample.pin_b        <= pin_b;
      s1_sample.switch_level <= switch_level;
      s1_now                 <= TIME_BITS'(now_ms[KEEP_W-1:0]);
    end
  end

  reb_event_core #(
    .TIME_BITS        (TIME_BITS),
    .STEPS_PER_DETENT (STEPS_PER_DETENT)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .sample          (s1_sample),
    .now             (s1_now),
    .long_press_ms   (long_press_ms),
    .double_press_ms (double_press_ms),
    .event_next      (event_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_code <= event_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/reb_checker.sv */
// Port-level checks for rotary_encoder_button_events_top, attached by bind.
// Depends on reb_pkg for the event codes.
`timescale 1ns / 1ps
`default_nettype none

module reb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] event_code
);

  // A held result keeps its code until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("result changed or dropped while stalled");

  // Only the six defined codes are ever delivered.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_code == reb_pkg::EV_NONE)  || (event_code == reb_pkg::EV_CW) ||
                  (event_code == reb_pkg::EV_CCW)   || (event_code == reb_pkg::EV_CLICK) ||
                  (event_code == reb_pkg::EV_DOUBLE) || (event_code == reb_pkg::EV_LONG))
    else $error("undefined event code delivered");

  // With the result register empty, the block always takes a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A result can only appear after an accepted request has passed through the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind rotary_encoder_button_events_top reb_checker u_reb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_code (event_code)
);

`default_nettype wire

/* test/tb_rotary_encoder_button_events_top.sv */
// Self-checking testbench for rotary_encoder_button_events_top: encoder detents,
// click, double click and long press, checked against an event predictor in this file.
// Depends on reb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_rotary_encoder_button_events_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 50;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic                            pin_a;
  logic                            pin_b;
  logic                            switch_level;
  logic [reb_pkg::NOW_W-1:0]       now_ms;
  logic                            out_valid;
  logic                            out_ready;
  logic [2:0]                      event_code;
  logic                            cfg_wr_en;
  logic [reb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [reb_pkg::CFG_DATA_W-1:0]  cfg_data;

  rotary_encoder_button_events_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_a        (pin_a),
    .pin_b        (pin_b),
    .switch_level (switch_level),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_code   (event_code),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor state and its copy of the timing registers.
  logic [15:0] long_ms     = reb_pkg::LONG_PRESS_RESET;
  logic [15:0] dbl_ms      = reb_pkg::DOUBLE_PRESS_RESET;
  logic [1:0]  enc_last    = 2'b00;
  int          step_cnt    = 0;
  logic        btn_held    = 1'b0;
  logic [31:0] press_t     = '0;
  logic        click_wait  = 1'b0;
  logic [31:0] click_t     = '0;

  reb_pkg::event_code_t expected_events[$];
  int          mismatch_count = 0;
  int          sent_count = 0;
  int          hold_off_cycles = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  // Stimulus position: index into the forward pin cycle 00, 10, 11, 01.
  int          enc_pos = 0;
  logic        btn_level = 1'b1;
  logic [31:0] ms_now = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic reb_pkg::event_code_t predict_event(input logic a, input logic b,
                                                         input logic sw,
                                                         input logic [31:0] t);
    logic [1:0]  pins;
    logic [3:0]  trans;
    logic [31:0] hold_ms;
    logic [31:0] since_click;
    pins = {a, b};
    trans = {enc_last, pins};
    enc_last = pins;
    case (trans)
      reb_pkg::TR_FWD_0, reb_pkg::TR_FWD_1,
      reb_pkg::TR_FWD_2, reb_pkg::TR_FWD_3: step_cnt++;
      reb_pkg::TR_REV_0, reb_pkg::TR_REV_1,
      reb_pkg::TR_REV_2, reb_pkg::TR_REV_3: step_cnt--;
      default: ;
    endcase
    // A completed detent swallows the switch level and time of this sample.
    if (step_cnt >= reb_pkg::STEPS_PER_DETENT_DEFAULT) begin
      step_cnt = 0;
      return reb_pkg::EV_CW;
    end
    if (step_cnt <= -reb_pkg::STEPS_PER_DETENT_DEFAULT) begin
      step_cnt = 0;
      return reb_pkg::EV_CCW;
    end
    if (!sw && !btn_held) begin
      btn_held = 1'b1;
      press_t = t;
    end
    if (sw && btn_held) begin
      btn_held = 1'b0;
      hold_ms = t - press_t;
      since_click = t - click_t;
      if (hold_ms > long_ms) return reb_pkg::EV_LONG;
      if (click_wait && since_click < dbl_ms) begin
        click_wait = 1'b0;
        return reb_pkg::EV_DOUBLE;
      end
      click_wait = 1'b1;
      click_t = t;
    end
    since_click = t - click_t;
    if (click_wait && since_click > dbl_ms) begin
      click_wait = 1'b0;
      return reb_pkg::EV_CLICK;
    end
    return reb_pkg::EV_NONE;
  endfunction

  task automatic report_mismatch(input string what);
    // Printing is capped so a broken block cannot flood the log; counting is not.
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Entered and left at a falling edge. Valid stays high on return so that a
  // following request can go out without a gap; wait_for_results lowers it.
  task automatic send_sample(input logic a, input logic b, input logic sw,
                             input logic [31:0] t);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    pin_a        <= a;
    pin_b        <= b;
    switch_level <= sw;
    now_ms       <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_events.push_back(predict_event(a, b, sw, t));
    sent_count++;
    @(negedge clk);
  endtask

  // Moves the encoder by dir positions (0 keeps the pins, 2 flips both) and
  // advances the clock by adv milliseconds.
  task automatic step_input(input int dir, input logic sw, input logic [31:0] adv);
    logic [1:0] pins;
    enc_pos = (enc_pos + dir) & 3;
    case (enc_pos)
      0: pins = 2'b00;
      1: pins = 2'b10;
      2: pins = 2'b11;
      default: pins = 2'b01;
    endcase
    ms_now = ms_now + adv;
    btn_level = sw;
    send_sample(pins[1], pins[0], sw, ms_now);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    // Leave margin before touching the registers.
    repeat (4) @(negedge clk);
  endtask

  task automatic set_timing(input logic [15:0] long_v, input logic [15:0] dbl_v);
    cfg_wr_en <= 1'b1;
    cfg_index <= reb_pkg::REG_LONG_PRESS;
    cfg_data  <= long_v;
    @(negedge clk);
    cfg_index <= reb_pkg::REG_DOUBLE_PRESS;
    cfg_data  <= dbl_v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    long_ms = long_v;
    dbl_ms = dbl_v;
  endtask

  function automatic logic [31:0] pick_hold();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return (long_ms == 0) ? 32'd0 : long_ms - 1;
      2: return 32'(long_ms);
      3: return long_ms + 1;
      4: return $urandom_range(0, long_ms / 2 + 2);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_gap();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return (dbl_ms == 0) ? 32'd0 : dbl_ms - 1;
      2: return 32'(dbl_ms);
      3: return dbl_ms + 1;
      4: return $urandom_range(0, dbl_ms / 2 + 2);
      default: return $urandom_range(0, dbl_ms * 2 + 4);
    endcase
  endfunction

  task automatic test_detent_rotation();
    step_input(1, 1'b1, 1);
    step_input(1, 1'b1, 1);
    step_input(-1, 1'b1, 1);
    step_input(-1, 1'b1, 1);
    step_input(0, 1'b1, 1);
    step_input(2, 1'b1, 1);
  endtask

  task automatic test_button_gestures();
    ms_now = 32'd1000;
    // Single click, reported once the window has passed.
    step_input(0, 1'b0, 0);
    step_input(0, 1'b1, 10);
    step_input(0, 1'b1, 301);
    // Two quick clicks make a double click.
    step_input(0, 1'b0, 100);
    step_input(0, 1'b1, 5);
    step_input(0, 1'b0, 100);
    step_input(0, 1'b1, 10);
    // A hold of exactly the threshold is a click; a long press leaves it pending.
    step_input(0, 1'b0, 1000);
    step_input(0, 1'b1, 600);
    step_input(0, 1'b0, 10);
    step_input(0, 1'b1, 601);
    step_input(0, 1'b1, 1);
  endtask

  task automatic test_timestamp_wrap();
    ms_now = 32'hFFFF_FF00;
    step_input(1, 1'b0, 0);
    // The detent hides this release, so the hold goes on across the wrap.
    step_input(1, 1'b1, 32'hFF);
    step_input(0, 1'b1, 32'h101);
  endtask

  task automatic test_zero_thresholds();
    wait_for_results();
    set_timing(16'd0, 16'd0);
    step_input(0, 1'b0, 5);
    step_input(0, 1'b1, 0);
    step_input(0, 1'b1, 0);
    step_input(0, 1'b1, 1);
  endtask

  task automatic test_random_traffic(input logic [15:0] long_v, input logic [15:0] dbl_v,
                                     input int n_items);
    int first;
    int dir;
    wait_for_results();
    set_timing(long_v, dbl_v);
    ms_now = $urandom();
    first = sent_count;
    while (sent_count - first < n_items) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          dir = $urandom_range(0, 1) ? 1 : -1;
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) == 0)
              step_input($urandom_range(0, 1) ? 0 : 2, btn_level, pick_gap());
            else
              step_input(dir, ($urandom_range(0, 6) == 0) ? !btn_level : btn_level,
                         $urandom_range(0, 3));
          end
        end
        4, 5, 6, 7: begin
          step_input(0, 1'b0, pick_gap());
          step_input(0, 1'b1, pick_hold());
        end
        8: begin
          step_input(0, 1'b0, pick_gap());
          step_input(0, 1'b1, $urandom_range(0, 3));
          step_input(0, 1'b0, pick_gap());
          step_input(0, 1'b1, $urandom_range(0, 1));
        end
        default: begin
          // Noise: arbitrary pins, switch and a jump anywhere in time.
          enc_pos = $urandom_range(0, 3);
          step_input(0, 1'($urandom_range(0, 1)), $urandom());
        end
      endcase
    end
  endtask

  task automatic test_result_backpressure();
    wait_for_results();
    // The receiver stops for a long stretch while requests keep coming.
    hold_off_cycles = 60;
    tx_idle_on = 1'b0;
    repeat (30) step_input($urandom_range(0, 2) - 1, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 20));
    // Let everything drain before sending again.
    wait_for_results();
    tx_idle_on = 1'b1;
    repeat (20) step_input($urandom_range(0, 2) - 1, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 20));
  endtask

  initial begin : result_checker
    int stall;
    reb_pkg::event_code_t want;
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle_on = !rx_idle_on;
      stall = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting, event_code %0d",
                                  event_code));
      end else begin
        want = expected_events.pop_front();
        if (event_code !== want)
          report_mismatch($sformatf("event_code %0d, expected %0d", event_code, want));
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_sequence
    rst          = 1'b1;
    in_valid     = 1'b0;
    pin_a        = 1'b0;
    pin_b        = 1'b0;
    switch_level = 1'b1;
    now_ms       = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = reb_pkg::REG_LONG_PRESS;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_detent_rotation();
    test_button_gestures();
    test_timestamp_wrap();
    test_zero_thresholds();
    test_random_traffic(reb_pkg::LONG_PRESS_RESET, reb_pkg::DOUBLE_PRESS_RESET, 200);
    test_random_traffic(16'd20, 16'd10, 250);
    test_random_traffic(16'd0, 16'd0, 150);
    test_random_traffic(16'hFFFF, 16'hFFFF, 150);
    test_result_backpressure();
    test_random_traffic(16'hFFFF, 16'd0, 100);
    test_random_traffic(16'd0, 16'hFFFF, 100);
    test_random_traffic(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 150);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* rotary_encoder_button_events_top.f */
hdl/reb_pkg.sv
hdl/reb_event_core.sv
hdl/rotary_encoder_button_events_top.sv
hdl/reb_checker.sv
test/tb_rotary_encoder_button_events_top.sv
